[rtl/djs_pkg.sv]
package djs_pkg;

  localparam int MAX_JOBS    = 64;
  localparam int MAX_SLOTS   = 64;
  localparam int PROFIT_BITS = 16;

  localparam int IDX_W      = $clog2(MAX_JOBS);
  localparam int CNT_W      = $clog2(MAX_JOBS + 1);
  localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
  localparam int DL_W       = $clog2(MAX_SLOTS + 1);

  localparam int IN_PROFIT_W = 16;
  localparam int IN_DL_W     = 8;
  localparam int TOTAL_W     = 22;
  localparam int PLACED_W    = 7;

  // Batch descriptor handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             clip;
    logic             ovf;
  } desc_t;

  // Store read port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic [PROFIT_BITS-1:0] profit;
    logic [DL_W-1:0]        deadline;
  } job_t;

endpackage

[rtl/djs_queue.sv]
module djs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  djs_pkg::desc_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output djs_pkg::desc_t rd_data,
  output logic           q_empty
);

  djs_pkg::desc_t entry_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_data = entry_r[rp_r];

  // Two-entry descriptor FIFO
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en && !q_full) begin
        entry_r[wp_r] <= wr_data;
        wp_r          <= ~wp_r;
      end
      if (rd_en && !q_empty) rp_r <= ~rp_r;
      case ({wr_en && !q_full, rd_en && !q_empty})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/djs_front.sv]
module djs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [djs_pkg::IN_PROFIT_W-1:0] in_job_profit,
  input  logic [djs_pkg::IN_DL_W-1:0]     in_job_deadline,
  input  logic                          in_last_job,
  output logic                          q_wr,
  output djs_pkg::desc_t                q_wdata,
  input  logic                          q_full,
  input  logic                          release_i,
  input  djs_pkg::rd_req_t              rd_req,
  output djs_pkg::job_t                 rd_data
);

  djs_pkg::job_t mem [djs_pkg::MAX_JOBS];

  logic                     busy_r;
  logic [djs_pkg::CNT_W-1:0] count_r;
  logic                     clip_r, ovf_r;
  logic                     acc, clip_now, room;
  logic [djs_pkg::DL_W-1:0] dl_clip;

  assign full     = busy_r | q_full;
  assign acc      = push & ~full;
  assign clip_now = (in_job_deadline > djs_pkg::IN_DL_W'(djs_pkg::MAX_SLOTS));
  assign dl_clip  = clip_now ? djs_pkg::DL_W'(djs_pkg::MAX_SLOTS)
                             : djs_pkg::DL_W'(in_job_deadline);
  assign room     = (count_r < djs_pkg::CNT_W'(djs_pkg::MAX_JOBS));

  // Descriptor for the closing transfer of a batch
  assign q_wr          = acc & in_last_job;
  assign q_wdata.count = count_r + djs_pkg::CNT_W'(room);
  assign q_wdata.clip  = clip_r | clip_now;
  assign q_wdata.ovf   = ovf_r | ~room;

  // Job store: written on transfer, read by the back end
  always_ff @(posedge clk) begin
    if (acc && room) begin
      mem[count_r[djs_pkg::IDX_W-1:0]].profit   <= in_job_profit[djs_pkg::PROFIT_BITS-1:0];
      mem[count_r[djs_pkg::IDX_W-1:0]].deadline <= dl_clip;
    end
    if (rd_req.en) rd_data <= mem[rd_req.addr];
  end

  // Batch collection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
      clip_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      if (release_i) busy_r <= 1'b0;
      if (acc) begin
        if (in_last_job) begin
          busy_r  <= 1'b1;
          count_r <= '0;
          clip_r  <= 1'b0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= count_r + djs_pkg::CNT_W'(room);
          clip_r  <= clip_r | clip_now;
          ovf_r   <= ovf_r | ~room;
        end
      end
    end
  end

endmodule

[rtl/djs_back.sv]
module djs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  djs_pkg::desc_t                q_rdata,
  output logic                          q_rd,
  output logic                          release_o,
  output djs_pkg::rd_req_t              rd_req,
  input  djs_pkg::job_t                 rd_data,
  output logic                          empty,
  input  logic                          pop,
  output logic [djs_pkg::TOTAL_W-1:0]   out_total_profit,
  output logic [djs_pkg::PLACED_W-1:0]  out_jobs_placed,
  output logic                          out_deadline_clipped,
  output logic                          out_job_overflow
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SEARCH, S_DONE} state_t;

  state_t                          state_r;
  logic [djs_pkg::CNT_W-1:0]       cnt_r, scan_r;
  logic                            pend_r, have_r;
  logic [djs_pkg::IDX_W-1:0]       pend_idx_r, best_idx_r;
  logic [djs_pkg::PROFIT_BITS-1:0] best_prof_r;
  logic [djs_pkg::DL_W-1:0]        best_dl_r, slot_r, slot_m1;
  logic [djs_pkg::MAX_JOBS-1:0]    used_r;
  logic [djs_pkg::MAX_SLOTS-1:0]   map_r;
  logic [djs_pkg::TOTAL_W-1:0]     sum_r;
  logic [djs_pkg::PLACED_W-1:0]    placed_r;
  logic                            clip_r, ovf_r, out_vld_r, release_r;
  logic                            issue, better, done_go;

  assign issue   = (state_r == S_SCAN) && (scan_r < cnt_r);
  assign rd_req.en   = issue;
  assign rd_req.addr = scan_r[djs_pkg::IDX_W-1:0];
  assign better  = pend_r && !used_r[pend_idx_r] && (!have_r || rd_data.profit > best_prof_r);
  assign slot_m1 = slot_r - djs_pkg::DL_W'(1);
  assign q_rd    = (state_r == S_IDLE) && !q_empty;
  assign empty   = ~out_vld_r;
  assign release_o = release_r;
  // Result register free, or emptied by this transfer
  assign done_go = (state_r == S_DONE) && (!out_vld_r || pop);

  // Selection scan, slot walk and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      release_r <= 1'b0;
      pend_r    <= 1'b0;
      have_r    <= 1'b0;
    end else begin
      release_r <= done_go;
      if (done_go) out_vld_r <= 1'b1;
      else if (pop && out_vld_r) out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cnt_r    <= q_rdata.count;
            clip_r   <= q_rdata.clip;
            ovf_r    <= q_rdata.ovf;
            used_r   <= '0;
            map_r    <= '0;
            sum_r    <= '0;
            placed_r <= '0;
            scan_r   <= '0;
            pend_r   <= 1'b0;
            have_r   <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_r     <= issue;
          pend_idx_r <= scan_r[djs_pkg::IDX_W-1:0];
          if (issue) scan_r <= scan_r + djs_pkg::CNT_W'(1);
          if (better) begin
            have_r      <= 1'b1;
            best_idx_r  <= pend_idx_r;
            best_prof_r <= rd_data.profit;
            best_dl_r   <= rd_data.deadline;
          end
          if (!issue && !pend_r) begin
            if (have_r) begin
              used_r[best_idx_r] <= 1'b1;
              slot_r             <= best_dl_r;
              state_r            <= S_SEARCH;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          if (slot_r == '0 || !map_r[slot_m1[djs_pkg::SLOT_IDX_W-1:0]]) begin
            if (slot_r != '0) begin
              map_r[slot_m1[djs_pkg::SLOT_IDX_W-1:0]] <= 1'b1;
              sum_r    <= sum_r + djs_pkg::TOTAL_W'(best_prof_r);
              placed_r <= placed_r + djs_pkg::PLACED_W'(1);
            end
            scan_r  <= '0;
            pend_r  <= 1'b0;
            have_r  <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            slot_r <= slot_m1;
          end
        end
        S_DONE: begin
          if (done_go) begin
            out_total_profit     <= sum_r;
            out_jobs_placed      <= placed_r;
            out_deadline_clipped <= clip_r;
            out_job_overflow     <= ovf_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/deadline_job_sequencer.sv]
// Greedy job sequencer with deadlines.
// Input queue: present a job on in_job_profit / in_job_deadline / in_last_job
// and raise push; the transfer happens on a clock edge with push high and full
// low. Jobs are stored (up to 64); the job with in_last_job set closes the
// batch. Result queue: while empty is low the batch result is on the out_
// ports; it is taken on an edge with pop high.
// Jobs load one per cycle while full is low. Scheduling then runs n + 1
// selection rounds: a scan of the job store, one read a cycle, each but
// the last followed by a backward walk of the slot map, one slot a cycle.
// The batch result then moves into the result register once that is free.
// full stays high from the closing transfer until the batch result has moved
// into the result register; the next batch may load while that result still
// waits to be popped. If the receiver stalls, the following batch result
// waits in the back end and full stays high.
// Reset (synchronous, rst_n low) clears the batch state and both queues.
module deadline_job_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_job_profit,
  input  logic [7:0]  in_job_deadline,
  input  logic        in_last_job,
  output logic        empty,
  input  logic        pop,
  output logic [21:0] out_total_profit,
  output logic [6:0]  out_jobs_placed,
  output logic        out_deadline_clipped,
  output logic        out_job_overflow
);

  logic             q_wr, q_full, q_rd, q_empty, rel;
  djs_pkg::desc_t   q_wdata, q_rdata;
  djs_pkg::rd_req_t rd_req;
  djs_pkg::job_t    rd_data;

  djs_front u_front (
    .clk, .rst_n, .push, .full, .in_job_profit, .in_job_deadline, .in_last_job,
    .q_wr, .q_wdata, .q_full, .release_i(rel), .rd_req, .rd_data
  );

  djs_queue u_queue (
    .clk, .rst_n, .wr_en(q_wr), .wr_data(q_wdata), .q_full,
    .rd_en(q_rd), .rd_data(q_rdata), .q_empty
  );

  djs_back u_back (
    .clk, .rst_n, .q_empty, .q_rdata, .q_rd, .release_o(rel), .rd_req, .rd_data,
    .empty, .pop, .out_total_profit, .out_jobs_placed, .out_deadline_clipped,
    .out_job_overflow
  );

endmodule

[rtl/djs_checker.sv]
module djs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        in_last_job,
  input logic        empty,
  input logic        pop,
  input logic [21:0] out_total_profit,
  input logic [6:0]  out_jobs_placed
);

  // A waiting result holds until transferred
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_total_profit) && $stable(out_jobs_placed))
    else $error("result changed while waiting");

  // Closing transfer locks the input side
  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_last_job |=> full)
    else $error("input not blocked after batch close");

  // Never more placed than storage holds
  a_placed: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_jobs_placed <= 7'd64)
    else $error("placed count out of range");

  // After reset the result side is empty
  a_rst: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

endmodule

bind deadline_job_sequencer djs_checker u_djs_checker (
  .clk, .rst_n, .push, .full, .in_last_job, .empty, .pop,
  .out_total_profit, .out_jobs_placed
);
